// ----- rtl/dem_void_fill_3x3_assert.svh -----
// assertion macros shared by the rtl
`ifndef DEM_VOID_FILL_3X3_ASSERT_SVH
`define DEM_VOID_FILL_3X3_ASSERT_SVH

`ifndef SYNTHESIS
`define DVF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define DVF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error(msg);
`else
`define DVF_ASSERT(lbl, prop, msg)
`define DVF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/dvf_pkg.sv -----
package dvf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WCFG_W      = 11;
    localparam int ROW_W       = 16;
    localparam int THR_W       = 4;
    localparam int HEIGHT_W    = 24;
    localparam int CELL_W      = HEIGHT_W + 1;
    localparam int SUM_W       = HEIGHT_W + 3;
    localparam int CNT_W       = 4;
    localparam int WIN_CELLS   = 9;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_THRESHOLD = 2'd2;

    localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(1024);
    localparam logic [ROW_W-1:0]  HEIGHT_RESET = ROW_W'(1024);
    localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(3);

    // void flag on top of the height
    localparam logic [CELL_W-1:0] VOID_CELL = {1'b1, {HEIGHT_W{1'b0}}};

    // neighbor masks, window position p = row * 3 + column
    localparam logic [WIN_CELLS-1:0] NB_LEFT  = 9'b111101111;
    localparam logic [WIN_CELLS-1:0] NB_RIGHT = 9'b110010110;

    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 31;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic                       centre_void;
        logic signed [HEIGHT_W-1:0] centre_height;
        logic signed [SUM_W-1:0]    sum;
        logic [CNT_W-1:0]           count;
        logic                       last;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_slot;

    // ceil(2^30 / count), exact floor quotient for magnitudes below 2^27
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        case (count)
            4'd1:    r = 31'd1073741824;
            4'd2:    r = 31'd536870912;
            4'd3:    r = 31'd357913942;
            4'd4:    r = 31'd268435456;
            4'd5:    r = 31'd214748365;
            4'd6:    r = 31'd178956971;
            4'd7:    r = 31'd153391690;
            4'd8:    r = 31'd134217728;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/dvf_channels.sv -----
interface dvf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic signed [dvf_pkg::HEIGHT_W-1:0]  height_in;
    logic                                 void_in;

    modport source (output valid, cmd, height_in, void_in, input ready);
    modport sink (input valid, cmd, height_in, void_in, output ready);
endinterface

interface dvf_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dvf_pkg::HEIGHT_W-1:0]  height_out;
    logic                                 void_out;
    logic                                 last_of_frame;

    modport source (output valid, height_out, void_out, last_of_frame, input ready);
    modport sink (input valid, height_out, void_out, last_of_frame, output ready);
endinterface

// ----- rtl/dvf_ram.sv -----
module dvf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dvf_front.sv -----
`include "dem_void_fill_3x3_assert.svh"

module dvf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    dvf_in_if.sink                       i_in,
    input  logic [dvf_pkg::WCFG_W-1:0]   i_width,
    input  logic [dvf_pkg::ROW_W-1:0]    i_height,
    input  logic                         i_full,
    output dvf_pkg::t_job_slot           o_push
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_J1   = 2'd2;
    localparam logic [1:0] ST_J2   = 2'd3;

    logic [1:0]                         r_state, n_state;
    logic [dvf_pkg::COL_W-1:0]          r_col, n_col;
    logic [dvf_pkg::ROW_W-1:0]          r_row, n_row;
    logic [dvf_pkg::CELL_W-1:0]         r_win [dvf_pkg::WIN_CELLS];
    logic [dvf_pkg::CELL_W-1:0]         r_cell;
    logic [dvf_pkg::COL_W-1:0]          r_jcol;
    logic                               r_j1, r_j2, r_last, r_top, r_bot, r_k0, r_k1;

    logic                               acc, draining, active, in_row, go, row_end, row_ok;
    logic [dvf_pkg::WCFG_W-1:0]         col_ext;
    logic [2*dvf_pkg::CELL_W-1:0]       rd_data;
    logic [dvf_pkg::CELL_W-1:0]         rd_older, rd_recent;
    logic                               sel_right;
    logic [dvf_pkg::WIN_CELLS-1:0]      row_okv, col_okv, voids, use_nb;
    logic signed [dvf_pkg::SUM_W-1:0]   nb_sum;

    assign i_in.ready = (r_state == ST_IDLE);
    assign acc        = i_in.valid && i_in.ready;
    assign draining   = (r_row >= i_height);
    assign col_ext    = {1'b0, r_col};
    assign active     = acc && (!i_in.cmd || draining);
    assign in_row     = (col_ext < i_width);
    assign go         = active && in_row;
    assign row_end    = active && (col_ext >= i_width - dvf_pkg::WCFG_W'(1));
    assign row_ok     = (r_row != '0) && (r_row <= i_height);

    // both line stores share one column address: {older, recent}
    dvf_ram #(
        .WIDTH (2 * dvf_pkg::CELL_W),
        .DEPTH (dvf_pkg::MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_LOAD),
        .i_waddr (r_jcol),
        .i_wdata ({rd_recent, r_cell}),
        .i_raddr (r_col),
        .o_rdata (rd_data)
    );

    assign rd_older  = rd_data[2*dvf_pkg::CELL_W-1:dvf_pkg::CELL_W];
    assign rd_recent = rd_data[dvf_pkg::CELL_W-1:0];

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (row_end) begin
            n_col = '0;
            n_row = draining ? '0 : r_row + dvf_pkg::ROW_W'(1);
        end else if (go) begin
            n_col = r_col + dvf_pkg::COL_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (go) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = r_j1 ? ST_J1 : (r_j2 ? ST_J2 : ST_IDLE);
            end
            ST_J1: begin
                if (!i_full) n_state = r_j2 ? ST_J2 : ST_IDLE;
            end
            ST_J2: begin
                if (!i_full) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            for (int p = 0; p < dvf_pkg::WIN_CELLS; p++) begin
                r_win[p] <= dvf_pkg::VOID_CELL;
            end
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            if (r_state == ST_LOAD) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i*3]   <= r_win[i*3+1];
                    r_win[i*3+1] <= r_win[i*3+2];
                end
                r_win[2] <= rd_older;
                r_win[5] <= rd_recent;
                r_win[8] <= r_cell;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_cell <= draining ? dvf_pkg::VOID_CELL : {i_in.void_in, i_in.height_in};
            r_jcol <= r_col;
            r_j1   <= row_ok && (r_col != '0);
            r_j2   <= row_ok && (col_ext == i_width - dvf_pkg::WCFG_W'(1));
            r_last <= (r_row == i_height);
            r_top  <= (r_row >= dvf_pkg::ROW_W'(2));
            r_bot  <= (r_row < i_height);
            r_k0   <= (r_col >= dvf_pkg::COL_W'(2));
            r_k1   <= (r_col != '0);
        end
    end

    // neighbor count and sum for the centre in window column 1 or 2
    assign sel_right = (r_state == ST_J2);
    assign row_okv   = {r_bot, r_bot, r_bot, 3'b111, r_top, r_top, r_top};
    assign col_okv   = {1'b1, r_k1, r_k0, 1'b1, r_k1, r_k0, 1'b1, r_k1, r_k0};

    always_comb begin
        for (int p = 0; p < dvf_pkg::WIN_CELLS; p++) begin
            voids[p] = r_win[p][dvf_pkg::CELL_W-1];
        end
    end

    assign use_nb = (sel_right ? dvf_pkg::NB_RIGHT : dvf_pkg::NB_LEFT)
                    & row_okv & col_okv & ~voids;

    always_comb begin
        nb_sum = '0;
        for (int p = 0; p < dvf_pkg::WIN_CELLS; p++) begin
            if (use_nb[p]) begin
                nb_sum = nb_sum
                    + dvf_pkg::SUM_W'($signed(r_win[p][dvf_pkg::HEIGHT_W-1:0]));
            end
        end
    end

    always_comb begin
        o_push.valid             = ((r_state == ST_J1) || (r_state == ST_J2)) && !i_full;
        o_push.job.centre_void   = sel_right ? r_win[5][dvf_pkg::CELL_W-1]
                                             : r_win[4][dvf_pkg::CELL_W-1];
        o_push.job.centre_height = sel_right ? r_win[5][dvf_pkg::HEIGHT_W-1:0]
                                             : r_win[4][dvf_pkg::HEIGHT_W-1:0];
        o_push.job.sum           = nb_sum;
        o_push.job.count         = dvf_pkg::CNT_W'($countones(use_nb));
        o_push.job.last          = sel_right && r_last;
    end

    `DVF_ASSERT_NEXT(a_load_after_go, go, r_state == ST_LOAD, "store access skipped load")

endmodule

// ----- rtl/dvf_queue.sv -----
`include "dem_void_fill_3x3_assert.svh"

module dvf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dvf_pkg::t_job_slot  i_push,
    output logic                o_full,
    output dvf_pkg::t_job_slot  o_head,
    input  logic                i_pop
);

    dvf_pkg::t_job                   r_mem [dvf_pkg::QUEUE_DEPTH];
    logic [dvf_pkg::QPTR_W-1:0]      r_wp, r_rp;
    logic [dvf_pkg::QPTR_W:0]        r_cnt, n_cnt;
    logic                            do_push, do_pop;

    assign o_full       = (r_cnt == (dvf_pkg::QPTR_W+1)'(dvf_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_mem[r_rp];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) n_cnt = r_cnt + (dvf_pkg::QPTR_W+1)'(1);
        if (!do_push && do_pop) n_cnt = r_cnt - (dvf_pkg::QPTR_W+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) r_wp <= r_wp + dvf_pkg::QPTR_W'(1);
            if (do_pop)  r_rp <= r_rp + dvf_pkg::QPTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

    `DVF_ASSERT(a_no_overflow, i_push.valid |-> !o_full, "push into full queue")
    `DVF_ASSERT(a_cnt_bound, r_cnt <= (dvf_pkg::QPTR_W+1)'(dvf_pkg::QUEUE_DEPTH), "count overrun")

endmodule

// ----- rtl/dvf_back.sv -----
`include "dem_void_fill_3x3_assert.svh"

module dvf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dvf_pkg::t_job_slot          i_head,
    output logic                        o_pop,
    input  logic [dvf_pkg::THR_W-1:0]   i_thr,
    dvf_out_if.source                   o_out
);

    localparam logic [1:0] KIND_VOID = 2'd0;
    localparam logic [1:0] KIND_PASS = 2'd1;
    localparam logic [1:0] KIND_MEAN = 2'd2;

    logic                                adv;
    logic [1:0]                          kind;
    logic [dvf_pkg::SUM_W-1:0]           abs_sum;

    logic                                r1_v, r2_v, r_ov;
    logic [1:0]                          r1_kind, r2_kind;
    logic [dvf_pkg::HEIGHT_W-1:0]        r1_height, r2_height;
    logic [dvf_pkg::SUM_W-1:0]           r1_abs;
    logic [dvf_pkg::RECIP_W-1:0]         r1_recip;
    logic                                r1_neg, r2_neg, r1_last, r2_last;
    logic [dvf_pkg::PROD_W-1:0]          r2_prod;
    logic [dvf_pkg::HEIGHT_W-1:0]        quot;
    logic [dvf_pkg::HEIGHT_W-1:0]        r_oh;
    logic                                r_ovoid, r_olast;

    assign adv   = !r_ov || o_out.ready;
    assign o_pop = adv && i_head.valid;

    always_comb begin
        if (i_head.job.count == '0) begin
            kind = KIND_VOID;
        end else if (!i_head.job.centre_void) begin
            kind = KIND_PASS;
        end else if (i_head.job.count > i_thr) begin
            kind = KIND_MEAN;
        end else begin
            kind = KIND_VOID;
        end
    end

    assign abs_sum = i_head.job.sum[dvf_pkg::SUM_W-1] ? dvf_pkg::SUM_W'(-i_head.job.sum)
                                                      : dvf_pkg::SUM_W'(i_head.job.sum);
    assign quot    = r2_prod[dvf_pkg::RECIP_SHIFT +: dvf_pkg::HEIGHT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r1_v <= i_head.valid;
            r2_v <= r1_v;
            r_ov <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_kind   <= kind;
            r1_height <= i_head.job.centre_height;
            r1_abs    <= abs_sum;
            r1_neg    <= i_head.job.sum[dvf_pkg::SUM_W-1];
            r1_recip  <= dvf_pkg::recip(i_head.job.count);
            r1_last   <= i_head.job.last;

            r2_kind   <= r1_kind;
            r2_height <= r1_height;
            r2_neg    <= r1_neg;
            r2_last   <= r1_last;
            r2_prod   <= dvf_pkg::PROD_W'(r1_abs) * dvf_pkg::PROD_W'(r1_recip);

            r_olast   <= r2_last;
            case (r2_kind)
                KIND_PASS: begin
                    r_oh    <= r2_height;
                    r_ovoid <= 1'b0;
                end
                KIND_MEAN: begin
                    r_oh    <= r2_neg ? -quot : quot;
                    r_ovoid <= 1'b0;
                end
                default: begin
                    r_oh    <= '0;
                    r_ovoid <= 1'b1;
                end
            endcase
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.height_out    = r_oh;
    assign o_out.void_out      = r_ovoid;
    assign o_out.last_of_frame = r_olast;

    `DVF_ASSERT(a_void_zero, o_out.valid && o_out.void_out |-> o_out.height_out == '0, "void word carries height")

endmodule

// ----- rtl/dem_void_fill_3x3.sv -----
// 3x3 void repair for a row-ordered elevation grid (signed Q16.8 heights with a void flag):
// each output word is the cell one row and one column behind the input, made void when no
// in-grid neighbor is valid, passed unchanged when valid, and otherwise filled with the
// truncated mean of its valid neighbors when their count exceeds fill_threshold, else void. After the
// last cell send flush words (cmd = 1) for one more row to drain the final row; flush words
// sent earlier are dropped. A grid cell holds the input through a registered line-store read,
// then store write-back and window shift, then a step for each result it produces, which
// waits while the queue is full; dropped words are taken without leaving idle. Results
// pass through a four-entry queue and a two-stage reciprocal-multiply divider before the
// output register. Write configuration only while the block is idle.
module dem_void_fill_3x3 (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dvf_in_if.sink                           i_in,
    dvf_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [dvf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dvf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [dvf_pkg::WCFG_W-1:0]  r_grid_width;
    logic [dvf_pkg::ROW_W-1:0]   r_grid_height;
    logic [dvf_pkg::THR_W-1:0]   r_fill_threshold;
    logic [dvf_pkg::WCFG_W-1:0]  width_eff;
    logic [dvf_pkg::ROW_W-1:0]   height_eff;
    logic                        q_full, q_pop;
    dvf_pkg::t_job_slot          push, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width     <= dvf_pkg::WIDTH_RESET;
            r_grid_height    <= dvf_pkg::HEIGHT_RESET;
            r_fill_threshold <= dvf_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dvf_pkg::CFG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_data[dvf_pkg::WCFG_W-1:0];
                end
                dvf_pkg::CFG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_data[dvf_pkg::ROW_W-1:0];
                end
                dvf_pkg::CFG_FILL_THRESHOLD: begin
                    r_fill_threshold <= i_cfg_data[dvf_pkg::THR_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_grid_width == '0) begin
            width_eff = dvf_pkg::WCFG_W'(1);
        end else if (r_grid_width > dvf_pkg::WCFG_W'(dvf_pkg::MAX_WIDTH)) begin
            width_eff = dvf_pkg::WCFG_W'(dvf_pkg::MAX_WIDTH);
        end else begin
            width_eff = r_grid_width;
        end
    end

    assign height_eff = (r_grid_height == '0) ? dvf_pkg::ROW_W'(1) : r_grid_height;

    dvf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_width  (width_eff),
        .i_height (height_eff),
        .i_full   (q_full),
        .o_push   (push)
    );

    dvf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (q_pop)
    );

    dvf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (q_pop),
        .i_thr   (r_fill_threshold),
        .o_out   (o_out)
    );

endmodule
